### hw/rtl/fls_pkg.sv
// Shared types, opcodes and constants of the logistic-regression step engine.
// Used by fls_ctrl, fls_datapath and finito_logistic_step; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fls_pkg;

  localparam int SAMPLES_DEF  = 1024;
  localparam int FEATURES_DEF = 16;

  localparam logic [1:0] OP_LOAD_FEATURE = 2'd0;
  localparam logic [1:0] OP_LOAD_LABEL   = 2'd1;
  localparam logic [1:0] OP_STEP         = 2'd2;
  localparam logic [1:0] OP_READ_MEAN    = 2'd3;

  localparam logic [1:0] CFG_STEP_SIZE  = 2'd0;
  localparam logic [1:0] CFG_REG_WEIGHT = 2'd1;
  localparam logic [1:0] CFG_INV_COUNT  = 2'd2;

  localparam logic [30:0] STEP_SIZE_RST  = 31'd655;
  localparam logic [30:0] REG_WEIGHT_RST = 31'd0;
  localparam logic [16:0] INV_COUNT_RST  = 17'd64;

  localparam logic [2:0] MUL_MX = 3'd0;
  localparam logic [2:0] MUL_YD = 3'd1;
  localparam logic [2:0] MUL_GY = 3'd2;
  localparam logic [2:0] MUL_GX = 3'd3;
  localparam logic [2:0] MUL_SM = 3'd4;
  localparam logic [2:0] MUL_AG = 3'd5;
  localparam logic [2:0] MUL_DI = 3'd6;

  typedef struct packed {
    logic       accept;
    logic       clr;
    logic       rd;
    logic       rd_mean;
    logic       mul_en;
    logic [2:0] mul_sel;
    logic       acc_clr;
    logic       acc_en;
    logic       dot_ld;
    logic       g_ld;
    logic       gy_ld;
    logic       gx_ld;
    logic       grad_ld;
    logic       delta_ld;
    logic       wr;
    logic       cnt_clr;
    logic       cnt_inc;
    logic       out_ld;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic cnt_last;
    logic row_ok;
  } status_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/finito_logistic_step.sv
// Top level of the incremental-gradient logistic-regression step engine.
// Loads are written when accepted. A mean read passes through ST_RDM to
// ST_OUT, where its result waits while the output is held. An update step
// holds the input through its dot and update loops on the shared multiplier.
// After reset a clearing pass over SAMPLES*FEATURES entries precedes all input.
// Depends on fls_pkg, fls_ctrl and fls_datapath.
`timescale 1ns / 1ps
`default_nettype none

module finito_logistic_step #(
  parameter int SAMPLES  = fls_pkg::SAMPLES_DEF,
  parameter int FEATURES = fls_pkg::FEATURES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         in_opcode,
  input  wire logic [9:0]         in_sample_index,
  input  wire logic [3:0]         in_feature_index,
  input  wire logic signed [31:0] in_value,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_weight,
  output logic [3:0]              out_weight_index,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);

  fls_pkg::cmd_t    cmd;
  fls_pkg::status_t status;

  assign cfg_ready = 1'b1;

  fls_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_opcode (in_opcode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  fls_datapath #(
    .SAMPLES  (SAMPLES),
    .FEATURES (FEATURES)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .in_opcode        (in_opcode),
    .in_sample_index  (in_sample_index),
    .in_feature_index (in_feature_index),
    .in_value         (in_value),
    .cfg_we           (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_weight       (out_weight),
    .out_weight_index (out_weight_index)
  );

endmodule

`default_nettype wire

### hw/rtl/fls_ctrl.sv
// Sequencer of the step engine: clearing pass, opcode dispatch, update loops.
// Depends on fls_pkg; drives fls_datapath through cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module fls_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [1:0]       in_opcode,
  output logic                  out_valid,
  input  wire logic             out_ready,
  input  wire fls_pkg::status_t status,
  output fls_pkg::cmd_t         cmd
);

  localparam logic [4:0] ST_CLR  = 5'd0;
  localparam logic [4:0] ST_IDLE = 5'd1;
  localparam logic [4:0] ST_RDM  = 5'd2;
  localparam logic [4:0] ST_OUT  = 5'd3;
  localparam logic [4:0] ST_DRD  = 5'd4;
  localparam logic [4:0] ST_DMUL = 5'd5;
  localparam logic [4:0] ST_DACC = 5'd6;
  localparam logic [4:0] ST_DSAT = 5'd7;
  localparam logic [4:0] ST_TMUL = 5'd8;
  localparam logic [4:0] ST_GSET = 5'd9;
  localparam logic [4:0] ST_GMUL = 5'd10;
  localparam logic [4:0] ST_GYST = 5'd11;
  localparam logic [4:0] ST_URD  = 5'd12;
  localparam logic [4:0] ST_UGX  = 5'd13;
  localparam logic [4:0] ST_USM  = 5'd14;
  localparam logic [4:0] ST_UGR  = 5'd15;
  localparam logic [4:0] ST_UAG  = 5'd16;
  localparam logic [4:0] ST_UDL  = 5'd17;
  localparam logic [4:0] ST_UDI  = 5'd18;
  localparam logic [4:0] ST_UWR  = 5'd19;

  logic [4:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_CLR: begin
        cmd.clr = 1'b1;
        if (status.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          cmd.cnt_clr = 1'b1;
          cmd.acc_clr = 1'b1;
          if (in_opcode == fls_pkg::OP_READ_MEAN) begin
            state_nxt = ST_RDM;
          end else if (in_opcode == fls_pkg::OP_STEP && status.row_ok) begin
            state_nxt = ST_DRD;
          end
        end
      end
      ST_RDM: begin
        cmd.rd_mean = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_ld = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_DRD: begin
        cmd.rd = 1'b1;
        state_nxt = ST_DMUL;
      end
      ST_DMUL: begin
        cmd.mul_en = 1'b1;
        cmd.mul_sel = fls_pkg::MUL_MX;
        state_nxt = ST_DACC;
      end
      ST_DACC: begin
        cmd.acc_en = 1'b1;
        if (status.cnt_last) begin
          cmd.cnt_clr = 1'b1;
          state_nxt = ST_DSAT;
        end else begin
          cmd.cnt_inc = 1'b1;
          state_nxt = ST_DRD;
        end
      end
      ST_DSAT: begin
        cmd.dot_ld = 1'b1;
        state_nxt = ST_TMUL;
      end
      ST_TMUL: begin
        cmd.mul_en = 1'b1;
        cmd.mul_sel = fls_pkg::MUL_YD;
        state_nxt = ST_GSET;
      end
      ST_GSET: begin
        cmd.g_ld = 1'b1;
        state_nxt = ST_GMUL;
      end
      ST_GMUL: begin
        cmd.mul_en = 1'b1;
        cmd.mul_sel = fls_pkg::MUL_GY;
        state_nxt = ST_GYST;
      end
      ST_GYST: begin
        cmd.gy_ld = 1'b1;
        state_nxt = ST_URD;
      end
      ST_URD: begin
        cmd.rd = 1'b1;
        state_nxt = ST_UGX;
      end
      ST_UGX: begin
        cmd.mul_en = 1'b1;
        cmd.mul_sel = fls_pkg::MUL_GX;
        state_nxt = ST_USM;
      end
      ST_USM: begin
        cmd.gx_ld = 1'b1;
        cmd.mul_en = 1'b1;
        cmd.mul_sel = fls_pkg::MUL_SM;
        state_nxt = ST_UGR;
      end
      ST_UGR: begin
        cmd.grad_ld = 1'b1;
        state_nxt = ST_UAG;
      end
      ST_UAG: begin
        cmd.mul_en = 1'b1;
        cmd.mul_sel = fls_pkg::MUL_AG;
        state_nxt = ST_UDL;
      end
      ST_UDL: begin
        cmd.delta_ld = 1'b1;
        state_nxt = ST_UDI;
      end
      ST_UDI: begin
        cmd.mul_en = 1'b1;
        cmd.mul_sel = fls_pkg::MUL_DI;
        state_nxt = ST_UWR;
      end
      ST_UWR: begin
        cmd.wr = 1'b1;
        if (status.cnt_last) begin
          state_nxt = ST_IDLE;
        end else begin
          cmd.cnt_inc = 1'b1;
          state_nxt = ST_URD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (cmd.out_ld) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> (state_r == ST_CLR && !out_valid_r))
    else $error("reset did not start clearing pass");
  a_step_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UWR && status.cnt_last) |=> state_r == ST_IDLE)
    else $error("update loop overran last feature");
  a_out_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT && (!out_valid_r || out_ready)) |=> out_valid_r)
    else $error("mean read lost its transfer");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wr || cmd.clr || cmd.rd) |-> !in_ready)
    else $error("input taken while busy");
`endif

endmodule

`default_nettype wire

### hw/rtl/fls_datapath.sv
// Datapath of the step engine: stores, shared Q16.16 multiplier, accumulator.
// Depends on fls_pkg; sequenced by fls_ctrl through cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module fls_datapath #(
  parameter int SAMPLES  = fls_pkg::SAMPLES_DEF,
  parameter int FEATURES = fls_pkg::FEATURES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire fls_pkg::cmd_t      cmd,
  output fls_pkg::status_t        status,
  input  wire logic [1:0]         in_opcode,
  input  wire logic [9:0]         in_sample_index,
  input  wire logic [3:0]         in_feature_index,
  input  wire logic signed [31:0] in_value,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  output logic signed [31:0]      out_weight,
  output logic [3:0]              out_weight_index
);

  localparam int TOTAL = SAMPLES * FEATURES;
  localparam int FA = (TOTAL > 1) ? $clog2(TOTAL) : 1;
  localparam int LA = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
  localparam int CW = (FEATURES > 1) ? $clog2(FEATURES) : 1;
  localparam int AW = 49 + CW;

  logic signed [31:0] feat_mem [TOTAL];
  logic signed [31:0] label_mem [SAMPLES];
  logic signed [31:0] z_mem [TOTAL];
  logic signed [31:0] mean_mem [FEATURES];

  logic [30:0] step_size_r, reg_weight_r;
  logic [16:0] inv_count_r;

  logic [FA-1:0] clr_r, base_r;
  logic [LA-1:0] row_r;
  logic [CW-1:0] cnt_r, col_addr_r;
  logic [3:0]    col_r;
  logic          col_ok_r;

  logic signed [31:0] m_rd_r, x_rd_r, z_rd_r, y_rd_r;
  logic signed [47:0] prod_r;
  logic signed [AW-1:0] acc_r;
  logic signed [31:0] dot_r, g_r, gy_r, gx_r, grad_r, delta_r;
  logic signed [31:0] out_weight_r;
  logic [3:0]         out_weight_index_r;

  logic               row_ok, col_ok;
  logic [FA-1:0]      feat_waddr, row_addr;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_full, mul_rnd;
  logic signed [31:0] prod_sat, t_val, m_new, z_new;
  logic signed [33:0] h_val;
  logic               mean_we;
  logic [CW-1:0]      mean_waddr;
  logic signed [31:0] mean_wdata;

  assign row_ok = 32'(in_sample_index) < 32'(SAMPLES);
  assign col_ok = 32'(in_feature_index) < 32'(FEATURES);
  assign feat_waddr = FA'(32'(in_sample_index) * 32'(FEATURES) + 32'(in_feature_index));
  assign row_addr = base_r + FA'(cnt_r);

  assign status.clr_last = clr_r == FA'(TOTAL - 1);
  assign status.cnt_last = cnt_r == CW'(FEATURES - 1);
  assign status.row_ok = row_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_size_r <= fls_pkg::STEP_SIZE_RST;
      reg_weight_r <= fls_pkg::REG_WEIGHT_RST;
      inv_count_r <= fls_pkg::INV_COUNT_RST;
      clr_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          fls_pkg::CFG_STEP_SIZE:  step_size_r <= cfg_data[30:0];
          fls_pkg::CFG_REG_WEIGHT: reg_weight_r <= cfg_data[30:0];
          fls_pkg::CFG_INV_COUNT:  inv_count_r <= cfg_data[16:0];
          default: ;
        endcase
      end
      if (cmd.clr) clr_r <= clr_r + FA'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      base_r <= FA'(32'(in_sample_index) * 32'(FEATURES));
      row_r <= LA'(in_sample_index);
      col_r <= in_feature_index;
      col_addr_r <= CW'(in_feature_index);
      col_ok_r <= col_ok;
      if (in_opcode == fls_pkg::OP_LOAD_FEATURE && row_ok && col_ok) begin
        feat_mem[feat_waddr] <= in_value;
      end
      if (in_opcode == fls_pkg::OP_LOAD_LABEL && row_ok) begin
        label_mem[LA'(in_sample_index)] <= in_value;
      end
    end
    if (cmd.rd) begin
      x_rd_r <= feat_mem[row_addr];
      z_rd_r <= z_mem[row_addr];
      y_rd_r <= label_mem[row_r];
    end
    if (cmd.clr) begin
      z_mem[clr_r] <= '0;
    end else if (cmd.wr) begin
      z_mem[row_addr] <= z_new;
    end
  end

  assign mean_we = (cmd.clr && 32'(clr_r) < 32'(FEATURES)) || cmd.wr;
  assign mean_waddr = cmd.clr ? clr_r[CW-1:0] : cnt_r;
  assign mean_wdata = cmd.clr ? 32'sd0 : m_new;

  always_ff @(posedge clk) begin
    if (mean_we) mean_mem[mean_waddr] <= mean_wdata;
    if (cmd.rd) begin
      m_rd_r <= mean_mem[cnt_r];
    end else if (cmd.rd_mean) begin
      m_rd_r <= mean_mem[col_addr_r];
    end
  end

  always_comb begin
    case (cmd.mul_sel)
      fls_pkg::MUL_MX: begin mul_a = m_rd_r; mul_b = x_rd_r; end
      fls_pkg::MUL_YD: begin mul_a = y_rd_r; mul_b = dot_r; end
      fls_pkg::MUL_GY: begin mul_a = g_r; mul_b = y_rd_r; end
      fls_pkg::MUL_GX: begin mul_a = gy_r; mul_b = x_rd_r; end
      fls_pkg::MUL_SM: begin mul_a = $signed({1'b0, reg_weight_r}); mul_b = m_rd_r; end
      fls_pkg::MUL_AG: begin mul_a = $signed({1'b0, step_size_r}); mul_b = grad_r; end
      fls_pkg::MUL_DI: begin mul_a = delta_r; mul_b = $signed({15'd0, inv_count_r}); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign mul_full = mul_a * mul_b;
  assign mul_rnd = (mul_full + 64'sd32768) >>> 16;
  assign prod_sat = fls_pkg::sat32({{16{prod_r[47]}}, prod_r});
  assign t_val = prod_sat;
  assign h_val = 34'sd32768 - ($signed({{2{t_val[31]}}, t_val}) >>> 2);
  assign z_new = fls_pkg::sat32({{32{z_rd_r[31]}}, z_rd_r} + {{32{delta_r[31]}}, delta_r});
  assign m_new = fls_pkg::sat32({{32{m_rd_r[31]}}, m_rd_r} + {{32{prod_sat[31]}}, prod_sat});

  always_ff @(posedge clk) begin
    if (cmd.mul_en) prod_r <= mul_rnd[47:0];
    if (cmd.acc_clr) begin
      acc_r <= '0;
    end else if (cmd.acc_en) begin
      acc_r <= acc_r + {{(AW-48){prod_r[47]}}, prod_r};
    end
    if (cmd.dot_ld) dot_r <= fls_pkg::sat32({{(64-AW){acc_r[AW-1]}}, acc_r});
    if (cmd.g_ld) begin
      if (h_val < 34'sd0) begin
        g_r <= 32'sd0;
      end else if (h_val > 34'sd65536) begin
        g_r <= -32'sd65536;
      end else begin
        g_r <= 32'sd0 - h_val[31:0];
      end
    end
    if (cmd.gy_ld) gy_r <= prod_sat;
    if (cmd.gx_ld) gx_r <= prod_sat;
    if (cmd.grad_ld) begin
      grad_r <= fls_pkg::sat32({{32{gx_r[31]}}, gx_r} + {{32{prod_sat[31]}}, prod_sat});
    end
    if (cmd.delta_ld) begin
      delta_r <= fls_pkg::sat32({{32{m_rd_r[31]}}, m_rd_r} - {{32{z_rd_r[31]}}, z_rd_r}
                                - {{32{prod_sat[31]}}, prod_sat});
    end
    if (cmd.out_ld) begin
      out_weight_r <= col_ok_r ? m_rd_r : 32'sd0;
      out_weight_index_r <= col_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.cnt_clr) begin
      cnt_r <= '0;
    end else if (cmd.cnt_inc) begin
      cnt_r <= cnt_r + CW'(1);
    end
  end

  assign out_weight = out_weight_r;
  assign out_weight_index = out_weight_index_r;

endmodule

`default_nettype wire
